// File: design/random_distribution_shaper_defines.svh
// Assertion macros used by the random distribution shaper RTL.
`ifndef RANDOM_DISTRIBUTION_SHAPER_DEFINES_SVH
`define RANDOM_DISTRIBUTION_SHAPER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on the rising clock, ignored while reset is high.
`define RDS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("random_distribution_shaper: assertion failed");

// Check a property on the rising clock, reset included.
`define RDS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("random_distribution_shaper: assertion failed");

`else

`define RDS_ASSERT(lbl, clk, rst, prop)
`define RDS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: design/rds_pkg.sv
// Types and constants of the random distribution shaper.
`default_nettype none

package rds_pkg;

   typedef enum logic [1:0] {
      MODE_UNIFORM   = 2'd0,
      MODE_BERNOULLI = 2'd1,
      MODE_NORMAL    = 2'd2
   } mode_type;

   localparam logic [1:0] REG_MODE    = 2'd0;
   localparam logic [1:0] REG_PARAM_A = 2'd1;
   localparam logic [1:0] REG_PARAM_B = 2'd2;

   localparam logic [31:0] PARAM_A_RESET = 32'h0000_0000;
   localparam logic [31:0] PARAM_B_RESET = 32'h0001_0000;
   localparam logic [31:0] ONE_Q16       = 32'h0001_0000;
   localparam logic [31:0] SHAPED_MAX    = 32'h7FFF_FFFF;
   localparam logic [31:0] SHAPED_MIN    = 32'h8000_0000;

   localparam logic [30:0] HALF_PI_Q30   = 31'd1686629713;
   localparam logic [30:0] TWO_LN2_Q30   = 31'd1488522236;
   localparam logic [32:0] INV_GAIN_Q30  = 33'd652032874;
   localparam logic [20:0] LOG_OF_ONE    = 21'd1572864;   // 24.0 in Q.16

   // Stage plan of one Box-Muller lane
   localparam int LOG_STEPS    = 16;
   localparam int W_STAGE      = LOG_STEPS + 1;
   localparam int ROOT_BITS    = 19;
   localparam int ROOT_LAST    = W_STAGE + ROOT_BITS;
   localparam int CORDIC_STEPS = 24;
   localparam int LANE_OUT     = ROOT_LAST + 1;

   localparam logic [31:0] ATAN_Q30 [0:CORDIC_STEPS-1] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

endpackage

`default_nettype wire

// File: design/random_distribution_shaper.sv
// Top level of the random distribution shaper: config registers, lanes, output stages.
//
//  channel   direction  handshake              payload
//  req_      in         tvalid/tready          tdata: uniform_0..uniform_3
//  rsp_      out        tvalid/tready          tdata: shaped_0..shaped_3
//  csr_      in         psel/penable/pready    APB registers mode, param_a, param_b
//
// One item enters per cycle while the output register is free; each item passes the lanes, scale and output stages.
// The depth is set by the log2 squarings (16 stages) followed by the square root
// (one bit per stage, 19 stages); the 24 CORDIC steps run beside them.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears the valid bits and loads the register reset values.
`default_nettype none

module random_distribution_shaper (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [95:0]  req_tdata,   // uniform_0, uniform_1, uniform_2, uniform_3
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // shaped_0, shaped_1, shaped_2, shaped_3
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import rds_pkg::*;

   `include "random_distribution_shaper_defines.svh"

   logic [1:0]         mode_ff;
   logic signed [31:0] param_a_ff;
   logic signed [31:0] param_b_ff;
   logic               csr_write;

   logic               en;
   logic [LANE_OUT+1:0] vld_ff, vld_in;
   logic [95:0]        smp_ff [0:LANE_OUT];
   logic signed [21:0] trig [4];
   logic signed [65:0] prod_ff [4];
   logic signed [65:0] prod_in [4];
   logic [3:0]         ber_ff, ber_in;
   logic               rsp_tvalid_ff;
   logic [127:0]       rsp_tdata_ff, rsp_tdata_in;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_UNIFORM;
         param_a_ff <= PARAM_A_RESET;
         param_b_ff <= PARAM_B_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_MODE:    mode_ff    <= csr_pwdata[1:0];
            REG_PARAM_A: param_a_ff <= csr_pwdata;
            REG_PARAM_B: param_b_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_MODE:    csr_prdata = {30'd0, mode_ff};
         REG_PARAM_A: csr_prdata = param_a_ff;
         REG_PARAM_B: csr_prdata = param_b_ff;
         default:     csr_prdata = '0;
      endcase
   end

   // Pipeline advance: every stage moves when the output register is free.
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;
   assign vld_in     = {vld_ff[LANE_OUT:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         vld_ff        <= vld_in;
         rsp_tvalid_ff <= vld_ff[LANE_OUT+1];
      end
   end

   // Carry the raw samples beside the lanes for the uniform and Bernoulli modes.
   always_ff @(posedge clock) begin
      if (en) begin
         smp_ff[0] <= req_tdata;
      end
   end

   for (genvar d = 1; d <= LANE_OUT; d++) begin : g_delay
      always_ff @(posedge clock) begin
         if (en) begin
            smp_ff[d] <= smp_ff[d-1];
         end
      end
   end

   rds_lane u_lane0 (
      .clock    (clock),
      .en       (en),
      .radius_u (req_tdata[23:0]),
      .angle_u  (req_tdata[47:24]),
      .cos_out  (trig[0]),
      .sin_out  (trig[1])
   );

   rds_lane u_lane1 (
      .clock    (clock),
      .en       (en),
      .radius_u (req_tdata[71:48]),
      .angle_u  (req_tdata[95:72]),
      .cos_out  (trig[2]),
      .sin_out  (trig[3])
   );

   // Scale stage: trig*b in normal mode, u*(b-a) otherwise.
   always_comb begin
      logic signed [32:0] span;
      logic signed [32:0] op_a;
      logic signed [32:0] op_b;
      logic signed [41:0] thr;
      logic [23:0]        u;
      span = 33'(param_b_ff) - 33'(param_a_ff);
      thr  = {{2{param_a_ff[31]}}, param_a_ff, 8'd0};
      for (int n = 0; n < 4; n++) begin
         u = smp_ff[LANE_OUT][24*n +: 24];
         if (mode_ff == MODE_NORMAL) begin
            op_a = 33'(trig[n]);
            op_b = 33'(param_b_ff);
         end else begin
            op_a = {9'd0, u};
            op_b = span;
         end
         prod_in[n] = op_a * op_b;
         ber_in[n]  = $signed({18'd0, u}) < thr;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         ber_ff  <= ber_in;
      end
   end

   // Output stage: shift, add the offset and saturate; Bernoulli mode gives 1.0 in Q16.16 or zero.
   always_comb begin
      logic signed [65:0] sh;
      logic signed [66:0] sum;
      logic [31:0]        sat;
      for (int n = 0; n < 4; n++) begin
         sh  = (mode_ff == MODE_NORMAL) ? (prod_ff[n] >>> 16) : (prod_ff[n] >>> 24);
         sum = 67'(sh) + 67'(param_a_ff);
         if (sum[66:31] != {36{sum[66]}}) begin
            sat = sum[66] ? SHAPED_MIN : SHAPED_MAX;
         end else begin
            sat = sum[31:0];
         end
         unique case (mode_ff)
            MODE_UNIFORM:   rsp_tdata_in[32*n +: 32] = sat;
            MODE_NORMAL:    rsp_tdata_in[32*n +: 32] = sat;
            MODE_BERNOULLI: rsp_tdata_in[32*n +: 32] = ber_ff[n] ? ONE_Q16 : 32'd0;
            default:        rsp_tdata_in[32*n +: 32] = 32'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `RDS_ASSERT(a_free_out_takes_input, clock, reset, !rsp_tvalid |-> req_tready)
   `RDS_ASSERT(a_transfer_enters_pipe, clock, reset, (req_tvalid && req_tready) |=> vld_ff[0])
   `RDS_ASSERT(a_stall_freezes_pipe, clock, reset, (rsp_tvalid && !rsp_tready) |=> $stable(vld_ff))
   `RDS_ASSERT_ALWAYS(a_reset_clears_out, clock, $past(reset) |-> !rsp_tvalid)

endmodule

`default_nettype wire

// File: design/rds_lane.sv
// Pipelined Box-Muller lane: log2, square root and CORDIC, one pair per cycle while en is high.
`default_nettype none

module rds_lane (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [23:0]        radius_u,
   input  wire logic [23:0]        angle_u,
   output logic signed [21:0]      cos_out,
   output logic signed [21:0]      sin_out
);
   import rds_pkg::*;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   typedef struct packed {
      logic [30:0]        m;
      logic [20:0]        lg;
      logic [37:0]        rem;
      logic [18:0]        root;
      logic signed [32:0] x;
      logic signed [32:0] y;
      logic signed [32:0] z;
      logic [1:0]         quad;
   } lane_stage_type;

   lane_stage_type     stage_ff [0:ROOT_LAST];
   lane_stage_type     first_in;
   logic signed [21:0] cos_ff, cos_in;
   logic signed [21:0] sin_ff, sin_in;

   // Normalize 1-u for the log and scale the angle fraction to radians.
   always_comb begin
      logic [24:0] v;
      logic [4:0]  k;
      logic [52:0] zp;
      v = 25'h100_0000 - {1'b0, radius_u};
      k = '0;
      for (int b = 0; b < 25; b++) begin
         if (v[b]) begin
            k = 5'(b);
         end
      end
      zp = {31'd0, angle_u[21:0]} * {22'd0, HALF_PI_Q30};
      first_in      = '0;
      first_in.m    = {6'd0, v} << (5'd30 - k);
      first_in.lg   = {k, 16'd0};
      first_in.x    = INV_GAIN_Q30;
      first_in.y    = '0;
      first_in.z    = 33'(zp[52:22]);
      first_in.quad = angle_u[23:22];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= first_in;
      end
   end

   for (genvar s = 1; s <= ROOT_LAST; s++) begin : g_stage
      localparam int LgBit = (s <= LOG_STEPS) ? LOG_STEPS - s : 0;
      localparam int SqBit = (s > W_STAGE) ? ROOT_LAST - s : 0;
      localparam int AtIdx = (s <= CORDIC_STEPS) ? s - 1 : 0;

      lane_stage_type nxt;

      always_comb begin
         logic [61:0]        sq;
         logic [20:0]        lval;
         logic [51:0]        wp;
         logic [38:0]        t;
         logic signed [32:0] dx;
         logic signed [32:0] dy;
         logic signed [32:0] at;
         nxt  = stage_ff[s-1];
         sq   = {31'd0, stage_ff[s-1].m} * {31'd0, stage_ff[s-1].m};
         lval = LOG_OF_ONE - stage_ff[s-1].lg;
         wp   = {31'd0, lval} * {21'd0, TWO_LN2_Q30};
         t    = ({20'd0, stage_ff[s-1].root} << (SqBit + 1)) + (39'd1 << (2 * SqBit));
         dx   = stage_ff[s-1].y >>> AtIdx;
         dy   = stage_ff[s-1].x >>> AtIdx;
         at   = 33'(ATAN_Q30[AtIdx]);
         // one fraction bit of log2 per squaring
         if (s <= LOG_STEPS) begin
            if (sq[61]) begin
               nxt.m  = sq[61:31];
               nxt.lg = stage_ff[s-1].lg | (21'd1 << LgBit);
            end else begin
               nxt.m  = sq[60:30];
            end
         end
         if (s == W_STAGE) begin
            nxt.rem  = wp[51:14];
            nxt.root = '0;
         end
         // one root bit per stage, remainder kept as w - root^2
         if (s > W_STAGE) begin
            if ({1'b0, stage_ff[s-1].rem} >= t) begin
               nxt.rem  = stage_ff[s-1].rem - t[37:0];
               nxt.root = stage_ff[s-1].root | (19'd1 << SqBit);
            end
         end
         if (s <= CORDIC_STEPS) begin
            if (!stage_ff[s-1].z[32]) begin
               nxt.x = stage_ff[s-1].x - dx;
               nxt.y = stage_ff[s-1].y + dy;
               nxt.z = stage_ff[s-1].z - at;
            end else begin
               nxt.x = stage_ff[s-1].x + dx;
               nxt.y = stage_ff[s-1].y - dy;
               nxt.z = stage_ff[s-1].z + at;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stage_ff[s] <= nxt;
         end
      end
   end

   // Map the quadrant and scale the unit vector by the radius.
   always_comb begin
      logic signed [32:0] cs;
      logic signed [32:0] sn;
      logic signed [19:0] rs;
      logic signed [52:0] pc;
      logic signed [52:0] ps;
      unique case (stage_ff[ROOT_LAST].quad)
         QUAD_0: begin
            cs = stage_ff[ROOT_LAST].x;
            sn = stage_ff[ROOT_LAST].y;
         end
         QUAD_1: begin
            cs = -stage_ff[ROOT_LAST].y;
            sn = stage_ff[ROOT_LAST].x;
         end
         QUAD_2: begin
            cs = -stage_ff[ROOT_LAST].x;
            sn = -stage_ff[ROOT_LAST].y;
         end
         QUAD_3: begin
            cs = stage_ff[ROOT_LAST].y;
            sn = -stage_ff[ROOT_LAST].x;
         end
         default: begin
            cs = '0;
            sn = '0;
         end
      endcase
      rs     = {1'b0, stage_ff[ROOT_LAST].root};
      pc     = rs * cs;
      ps     = rs * sn;
      cos_in = 22'(pc >>> 30);
      sin_in = 22'(ps >>> 30);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

`default_nettype wire
